FILE: design/ipv4p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_pkg: shared types and constants of the IPv4 dotted text parser
// Word layouts of both channels, the parser state and the character codes.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_OCT = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWF  = 8'h66;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_LOWX  = 8'h78;
  localparam logic [7:0] LOW_BIAS = 8'h57;
  localparam logic [7:0] UP_BIAS  = 8'h37;

  localparam logic [2:0] SEG_COUNT = 3'd4;
  localparam logic [1:0] POS_MAX   = 2'd2;
  localparam logic [4:0] NO_DIGIT  = 5'd16;
  localparam logic [7:0] BYTE_MAX  = 8'hFF;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } char_word_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] address_value;
  } addr_word_t;

  typedef struct packed {
    logic [2:0]  seg_idx;
    logic [1:0]  pos;
    logic [1:0]  mode;
    logic        seen;
    logic        ended;
    logic [7:0]  acc;
    logic        fail;
    logic [31:0] addr;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '0;

endpackage
`default_nettype wire

FILE: design/ipv4p_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4p_step: per-character update of the parser state
// Folds one character into the state and forms the result on a last word.
// ----------------------------------------------------------------------------
module ipv4p_step
  import ipv4p_pkg::*;
(
  input  var parse_state_t st,
  input  var char_word_t   word,
  output parse_state_t     st_next,
  output addr_word_t       result
);

  logic [7:0]   c;
  logic [4:0]   raw;
  logic [4:0]   dig;
  logic [11:0]  scaled;
  logic [11:0]  sum;
  parse_state_t mid;
  parse_state_t fin;

  assign c = word.text_char;

  always_comb begin
    if (c >= CH_ZERO && c <= CH_NINE) begin
      raw = {1'b0, c[3:0]};
    end else if (c >= CH_LOWA && c <= CH_LOWF) begin
      raw = 5'(c - LOW_BIAS);
    end else if (c >= CH_UPA && c <= CH_UPF) begin
      raw = 5'(c - UP_BIAS);
    end else begin
      raw = NO_DIGIT;
    end
    case (st.mode)
      MODE_HEX: dig = raw;
      MODE_OCT: dig = (raw < 5'd8) ? raw : NO_DIGIT;
      default:  dig = (raw < 5'd10) ? raw : NO_DIGIT;
    endcase
    case (st.mode)
      MODE_HEX: scaled = {st.acc, 4'b0};
      MODE_OCT: scaled = {1'b0, st.acc, 3'b0};
      default:  scaled = {1'b0, st.acc, 3'b0} + {3'b0, st.acc, 1'b0};
    endcase
    sum = scaled + {8'b0, dig[3:0]};
  end

  always_comb begin
    mid = st;
    if (st.seg_idx < SEG_COUNT) begin
      if (c == CH_DOT) begin
        mid       = STATE_CLEAR;
        mid.fail  = st.fail | ~st.seen;
        mid.addr  = {st.addr[23:0], st.acc};
        mid.seg_idx = st.seg_idx + 3'd1;
      end else begin
        if (st.pos == 2'd0 && c == CH_ZERO) begin
          mid.mode = MODE_OCT;
          mid.seen = 1'b1;
          mid.acc  = '0;
        end else if (st.pos == 2'd1 && st.mode == MODE_OCT && c == CH_LOWX) begin
          mid.mode  = MODE_HEX;
          mid.seen  = 1'b0;
          mid.ended = 1'b0;
          mid.acc   = '0;
        end else if (!st.ended) begin
          if (dig == NO_DIGIT) begin
            mid.ended = 1'b1;
          end else begin
            mid.seen = 1'b1;
            if (sum > 12'd255) begin
              mid.fail = 1'b1;
              mid.acc  = BYTE_MAX;
            end else begin
              mid.acc = sum[7:0];
            end
          end
        end
        mid.pos = (st.pos < POS_MAX) ? st.pos + 2'd1 : POS_MAX;
      end
    end

    fin = mid;
    if (mid.seg_idx < SEG_COUNT) begin
      fin.fail    = mid.fail | ~mid.seen;
      fin.addr    = {mid.addr[23:0], mid.acc};
      fin.seg_idx = mid.seg_idx + 3'd1;
    end

    result.parse_ok      = ~fin.fail && fin.seg_idx == SEG_COUNT;
    result.address_value = result.parse_ok ? fin.addr : '0;
    st_next = word.is_last ? STATE_CLEAR : mid;
  end

endmodule
`default_nettype wire

FILE: design/ipv4_dotted_text_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser_unit: IPv4 dotted address text parser
// Parses an address string one character per word into a 32-bit address.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake               Word
//  char_word   in   char_valid / char_stall text_char, is_last
//  addr_word   out  addr_valid / addr_stall parse_ok, address_value
//
// One character is taken every cycle while char_stall is low; the state register
// loops back through the combinational step. A word passes an input register and
// then the result register, which takes the result as its last character leaves.
// Reset clears the parser state and the valid bits of both registers.
// A last character waits in the input register only while a result is held
// and stalled; other characters keep flowing behind a stalled result.
module ipv4_dotted_text_parser_unit
  import ipv4p_pkg::*;
(
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       char_valid,
  output logic           char_stall,
  input  var char_word_t char_word,
  output logic           addr_valid,
  input  var logic       addr_stall,
  output addr_word_t     addr_word
);

  logic         s1_valid;
  char_word_t   s1_word;
  parse_state_t st;
  parse_state_t st_next;
  addr_word_t   result;
  logic         proc;

  ipv4p_step u_step (
    .st      (st),
    .word    (s1_word),
    .st_next (st_next),
    .result  (result)
  );

  assign proc       = s1_valid && (!s1_word.is_last || !addr_valid || !addr_stall);
  assign char_stall = s1_valid && !proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!char_stall) begin
      s1_valid <= char_valid;
    end
    if (!char_stall) begin
      s1_word <= char_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_CLEAR;
    end else if (proc) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_valid <= 1'b0;
    end else if (!addr_valid || !addr_stall) begin
      addr_valid <= proc && s1_word.is_last;
    end
    if (proc && s1_word.is_last) begin
      addr_word <= result;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    addr_valid && !addr_word.parse_ok |-> addr_word.address_value == '0)
    else $error("failed parse carries a nonzero address");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    st.seg_idx <= SEG_COUNT)
    else $error("segment index out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc && s1_word.is_last |=> st.seg_idx == 3'd0 && !st.fail && st.pos == 2'd0)
    else $error("state not cleared after last character");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> s1_valid && s1_word.is_last && addr_valid && addr_stall)
    else $error("input stalled without a held result");

endmodule
`default_nettype wire
